// File: rtl/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

  localparam int unsigned DepthDefault = 128;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 8;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 48;

  localparam logic [CmdW-1:0] CmdPushBack  = 3'd0;
  localparam logic [CmdW-1:0] CmdPushFront = 3'd1;
  localparam logic [CmdW-1:0] CmdPopBack   = 3'd2;
  localparam logic [CmdW-1:0] CmdPopFront  = 3'd3;
  localparam logic [CmdW-1:0] CmdPeekFront = 3'd4;
  localparam logic [CmdW-1:0] CmdPeekBack  = 3'd5;
  localparam logic [CmdW-1:0] CmdClear     = 3'd6;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StData  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;
  localparam logic [StatusW-1:0] StFull  = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } rbd_result_t;

endpackage

`default_nettype wire

// File: rtl/rbd_ram.sv
`default_nettype none

module rbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/rbd_ctrl.sv
`default_nettype none

module rbd_ctrl
  import rbd_pkg::*;
#(
  parameter int unsigned Depth = DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     fire_i,
  input  wire logic [CmdW-1:0]          command_i,
  input  wire logic [DataW-1:0]         push_value_i,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic      [$clog2(Depth)-1:0] ram_addr_o,
  output logic      [DataW-1:0]         ram_wdata_o,
  output rbd_result_t                   result_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic            full, empty;
  logic            we, re;
  logic [IdxW-1:0] addr;
  logic [StatusW-1:0] status;

  assign head_inc = (head_q == IdxLast) ? '0 : head_q + IdxW'(1);
  assign head_dec = (head_q == '0) ? IdxLast : head_q - IdxW'(1);
  assign tail_inc = (tail_q == IdxLast) ? '0 : tail_q + IdxW'(1);
  assign tail_dec = (tail_q == '0) ? IdxLast : tail_q - IdxW'(1);
  assign full     = (count_q == CntFull);
  assign empty    = (count_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    addr    = tail_q;
    status  = StOk;
    case (command_i)
      CmdPushBack: begin
        if (full) begin
          status = StFull;
        end else begin
          we      = 1'b1;
          addr    = tail_inc;
          tail_d  = tail_inc;
          count_d = count_q + CntW'(1);
        end
      end
      CmdPushFront: begin
        if (full) begin
          status = StFull;
        end else begin
          we      = 1'b1;
          addr    = head_dec;
          head_d  = head_dec;
          count_d = count_q + CntW'(1);
        end
      end
      CmdPopBack, CmdPeekBack: begin
        if (empty) begin
          status = StEmpty;
        end else begin
          status = StData;
          re     = 1'b1;
          addr   = tail_q;
          if (command_i == CmdPopBack) begin
            tail_d  = tail_dec;
            count_d = count_q - CntW'(1);
          end
        end
      end
      CmdPopFront, CmdPeekFront: begin
        if (empty) begin
          status = StEmpty;
        end else begin
          status = StData;
          re     = 1'b1;
          addr   = head_q;
          if (command_i == CmdPopFront) begin
            head_d  = head_inc;
            count_d = count_q - CntW'(1);
          end
        end
      end
      CmdClear: begin
        head_d  = IdxW'(1);
        tail_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= IdxW'(1);
      tail_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign ram_we_o    = fire_i & we;
  assign ram_re_o    = fire_i & re;
  assign ram_addr_o  = addr;
  assign ram_wdata_o = push_value_i;
  assign result_o    = {status, CountW'(count_d)};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("occupancy exceeds capacity");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> (head_q == tail_inc))
    else $error("head and tail disagree on an empty queue");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("store read and written in one cycle");

  a_push_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not raise the count");

endmodule

`default_nettype wire

// File: rtl/ring_buffer_deque_top.sv
// Result path: a command word's result is held in a pending register, then moved to the output register.
// A new command word is accepted only once the pending result has moved to the output register;
// the pending register covers the registered read port of the word store, and the move waits on m_axis_tready_i.
// Reset: head pointer 1, tail pointer 0, count 0, no result pending.
// The word store is not cleared; its entries are only read after being written.
`default_nettype none

module ring_buffer_deque_top
  import rbd_pkg::*;
#(
  parameter int unsigned Depth = DepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // command [2:0], push_value [34:3], zero padding [39:35].
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // status [1:0], read_value [33:2], entry_count [41:34], zero padding [47:42].
  output logic      [OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(Depth);

  logic              fire;
  logic              load_out;
  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_addr;
  logic [DataW-1:0]  ram_wdata, ram_rdata;
  rbd_result_t       result;
  logic              pend_q;
  rbd_result_t       pend_res_q;
  logic              out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [DataW-1:0]  out_value_q;
  logic [CountW-1:0] out_count_q;

  assign s_axis_tready_o = ~pend_q;
  assign fire            = s_axis_tvalid_i & s_axis_tready_o;
  assign load_out        = pend_q & (~out_valid_q | m_axis_tready_i);

  rbd_ctrl #(
    .Depth (Depth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .command_i    (s_axis_tdata_i[CmdW-1:0]),
    .push_value_i (s_axis_tdata_i[CmdW +: DataW]),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .result_o     (result)
  );

  rbd_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_res_q <= result;
    end
    if (load_out) begin
      out_status_q <= pend_res_q.status;
      out_value_q  <= (pend_res_q.status == StData) ? ram_rdata : '0;
      out_count_q  <= pend_res_q.count;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutTdataW - StatusW - DataW - CountW)'(0),
                            out_count_q, out_value_q, out_status_q};

  a_fire_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> pend_q)
    else $error("accepted command left no pending result");

  a_pend_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && !pend_q))
    else $error("pending result not moved to the output register");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !fire)
    else $error("command accepted while a result is pending");

endmodule

`default_nettype wire
